// ===== rtl/oar_pkg.sv =====
// Package for the octant average restriction unit: widths, types and the side clamp.
// No dependencies; every other file in rtl imports it.
`timescale 1ns / 1ps
`default_nettype none

package oar_pkg;

	localparam int MAX_SIDE    = 32;
	localparam int HALF_SIDE   = MAX_SIDE / 2;
	localparam int COORD_W     = $clog2(MAX_SIDE);
	localparam int HALF_W      = $clog2(HALF_SIDE);
	localparam int SLOT_W      = 2 * HALF_W;
	localparam int STORE_DEPTH = HALF_SIDE * HALF_SIDE;
	localparam int SIDE_W      = 6;
	localparam int SQ_W        = $clog2(MAX_SIDE * MAX_SIDE + 1);
	localparam int VALUE_W     = 32;
	localparam int SUM_W       = VALUE_W + 3;
	localparam int INDEX_W     = 15;
	localparam int IDXF_W      = SQ_W + COORD_W + 1;
	localparam int SIDE_RESET  = 16;
	localparam logic [2:0] LAST_OCTANT = 3'd7;

	typedef logic [SLOT_W-1:0]         slot_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic [COORD_W-1:0]        coord_t;
	typedef logic [SIDE_W-1:0]         side_t;

	// One write into the partial-sum store.
	typedef struct packed {
		logic  en;
		slot_t addr;
		sum_t  data;
	} store_wr_t;

	// Limit the side to the store size, force it even and keep it at least two.
	function automatic side_t eff_side(input side_t raw);
		side_t s;
		s = (raw > side_t'(MAX_SIDE)) ? side_t'(MAX_SIDE) : raw;
		s[0] = 1'b0;
		if (s < side_t'(2)) begin
			s = side_t'(2);
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/oar_sum_store.sv =====
// Partial-sum store: one sum per 2x2 column pair, with per-entry valid bits and write bypass.
// Depends on oar_pkg.
`timescale 1ns / 1ps
`default_nettype none

module oar_sum_store (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 clear,
	input  wire                 rd_en,
	input  oar_pkg::slot_t      rd_addr,
	input  oar_pkg::store_wr_t  wr,
	output oar_pkg::sum_t       rd_data
);
	import oar_pkg::*;

	sum_t                   mem [STORE_DEPTH];
	logic [STORE_DEPTH-1:0] entry_valid_q;
	sum_t                   mem_rd_q;
	sum_t                   byp_data_q;
	logic                   byp_hit_q;
	logic                   rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			mem_rd_q   <= mem[rd_addr];
			byp_data_q <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			byp_hit_q     <= 1'b0;
			rd_valid_q    <= 1'b0;
		end else begin
			if (clear) begin
				entry_valid_q <= '0;
			end else if (wr.en) begin
				entry_valid_q[wr.addr] <= 1'b1;
			end
			if (rd_en) begin
				// A write landing on the same entry at this edge is not yet in the array.
				byp_hit_q  <= wr.en && (wr.addr == rd_addr);
				rd_valid_q <= entry_valid_q[rd_addr];
			end
		end
	end

	assign rd_data = byp_hit_q ? byp_data_q : (rd_valid_q ? mem_rd_q : '0);

endmodule

`default_nettype wire

// ===== rtl/octant_average_restriction_unit.sv =====
// Top level of the octant average restriction unit: scan counters, sum pipeline, output register.
// Depends on oar_pkg and oar_sum_store.
`timescale 1ns / 1ps
`default_nettype none

// Usage.
// Fine samples arrive as words on the in channel (fine_value, in_valid, in_ready), in the
// order octant, z, y, x, for the eight child blocks of one coarse block. Each 2x2x2 group is
// summed in a 256-entry store; on the group's last sample (odd x, y and z) one result word
// leaves on the out channel (coarse_value, coarse_index, block_done, out_valid, out_ready).
// coarse_value is the group sum shifted right by three, block_done marks the final result of
// octant seven. Samples that close no group give no word.
// The side length is written through the cfg channel (cells_per_side, cfg_valid, cfg_ready);
// a write restarts the scan and empties the store at once through its valid bits. The user must
// make writes only while the unit is idle; the unit does not enforce it. cfg_ready is always high.
// Throughput is one sample per cycle while no result word waits on a stalled receiver: the store
// does a read-modify-write per sample, with the read registered at acceptance and a bypass for a
// write to the same entry in the same cycle. An accepted sample passes the sum stage register,
// and its result word, if it closes a group, is then shown from the output register.
// If the receiver stalls, the result word holds in the output register while samples that
// close no group keep flowing; the next group's closing sample then waits in the sum stage
// and in_ready stays low until the held word is taken.
// Reset sets the side to sixteen, clears the counters and the store, and empties the pipeline.

module octant_average_restriction_unit (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  in_valid,
	output logic                                 in_ready,
	input  wire signed [oar_pkg::VALUE_W-1:0]    fine_value,
	output logic                                 out_valid,
	input  wire                                  out_ready,
	output logic signed [oar_pkg::VALUE_W-1:0]   coarse_value,
	output logic [oar_pkg::INDEX_W-1:0]          coarse_index,
	output logic                                 block_done,
	input  wire                                  cfg_valid,
	output logic                                 cfg_ready,
	input  wire [oar_pkg::SIDE_W-1:0]            cells_per_side
);
	import oar_pkg::*;

	// Effective side and its square, refreshed on each configuration write.
	side_t             side_q;
	logic [SQ_W-1:0]   side_sq_q;
	side_t             side_m1;
	side_t             new_side;

	coord_t            x_q, y_q, z_q;
	logic [2:0]        oct_q;

	logic              cfg_wr;
	logic              accept;
	logic              last_x, last_y, last_z;
	logic              pos_emit;
	logic              pos_last;
	logic [SIDE_W-1:0] cx_full, cy_full, cz_full;
	slot_t             slot;

	// Sum stage.
	logic                       valid_s1;
	logic                       emit_s1;
	logic                       last_s1;
	logic signed [VALUE_W-1:0]  value_s1;
	slot_t                      slot_s1;
	coord_t                     cx_s1, cy_s1, cz_s1;
	logic                       s1_go;
	sum_t                       old_sum;
	sum_t                       new_sum;
	logic [IDXF_W-1:0]          index_full;
	store_wr_t                  store_wr;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign new_side  = eff_side(cells_per_side);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q    <= side_t'(SIDE_RESET);
			side_sq_q <= SQ_W'(SIDE_RESET * SIDE_RESET);
		end else if (cfg_wr) begin
			side_q    <= new_side;
			side_sq_q <= SQ_W'(new_side) * SQ_W'(new_side);
		end
	end

	// Scan position of the incoming sample.
	assign side_m1  = side_q - side_t'(1);
	assign last_x   = ({1'b0, x_q} == side_m1);
	assign last_y   = ({1'b0, y_q} == side_m1);
	assign last_z   = ({1'b0, z_q} == side_m1);
	assign pos_emit = x_q[0] && y_q[0] && z_q[0];
	assign pos_last = (oct_q == LAST_OCTANT) && last_x && last_y && last_z;
	assign slot     = {y_q[COORD_W-1:1], x_q[COORD_W-1:1]};

	// Coarse coordinates: the octant bit moves the fine coordinate into the upper half.
	assign cx_full = {1'b0, x_q} + (oct_q[0] ? side_q : '0);
	assign cy_full = {1'b0, y_q} + (oct_q[1] ? side_q : '0);
	assign cz_full = {1'b0, z_q} + (oct_q[2] ? side_q : '0);

	assign s1_go    = !emit_s1 || !out_valid || out_ready;
	assign in_ready = !valid_s1 || s1_go;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			z_q   <= '0;
			oct_q <= '0;
		end else if (cfg_wr) begin
			x_q   <= '0;
			y_q   <= '0;
			z_q   <= '0;
			oct_q <= '0;
		end else if (accept) begin
			if (!last_x) begin
				x_q <= x_q + coord_t'(1);
			end else begin
				x_q <= '0;
				if (!last_y) begin
					y_q <= y_q + coord_t'(1);
				end else begin
					y_q <= '0;
					if (!last_z) begin
						z_q <= z_q + coord_t'(1);
					end else begin
						z_q   <= '0;
						oct_q <= oct_q + 3'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			emit_s1  <= pos_emit;
			last_s1  <= pos_last;
			value_s1 <= fine_value;
			slot_s1  <= slot;
			cx_s1    <= cx_full[SIDE_W-1:1];
			cy_s1    <= cy_full[SIDE_W-1:1];
			cz_s1    <= cz_full[SIDE_W-1:1];
		end
	end

	assign new_sum = old_sum + {{(SUM_W - VALUE_W){value_s1[VALUE_W-1]}}, value_s1};
	assign index_full = IDXF_W'(cx_s1)
	                  + IDXF_W'(cy_s1) * IDXF_W'(side_q)
	                  + IDXF_W'(cz_s1) * IDXF_W'(side_sq_q);

	// A finished group leaves its entry at zero for the next z pair.
	assign store_wr.en   = valid_s1 && s1_go;
	assign store_wr.addr = slot_s1;
	assign store_wr.data = emit_s1 ? '0 : new_sum;

	oar_sum_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.clear   (cfg_wr),
		.rd_en   (accept),
		.rd_addr (slot),
		.wr      (store_wr),
		.rd_data (old_sum)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (valid_s1 && emit_s1 && s1_go) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && emit_s1 && s1_go) begin
			// The arithmetic shift by three is the floor of the division by eight.
			coarse_value <= new_sum[SUM_W-1:3];
			coarse_index <= index_full[INDEX_W-1:0];
			block_done   <= last_s1;
		end
	end

	a_write_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		store_wr.en |-> valid_s1)
		else $error("store written without an item in the sum stage");

	a_emit_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos_emit) |=> (valid_s1 && emit_s1))
		else $error("group closing sample lost on its way to the sum stage");

	a_counters_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, x_q} <= side_m1) && ({1'b0, y_q} <= side_m1) && ({1'b0, z_q} <= side_m1))
		else $error("scan counter beyond the side length");

	a_cfg_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_wr |=> (x_q == '0) && (y_q == '0) && (z_q == '0) && (oct_q == '0))
		else $error("configuration write did not restart the scan");

endmodule

`default_nettype wire
